// File: sv/sprite_evaluation_with_dot_timing_macros.svh
// Assertion macros shared by the sprite evaluation RTL.
`ifndef SPRITE_EVALUATION_WITH_DOT_TIMING_MACROS_SVH
`define SPRITE_EVALUATION_WITH_DOT_TIMING_MACROS_SVH

// Same-cycle implication, clocked on aclk and idle while aresetn is low.
`define SPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and idle while aresetn is low.
`define SPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/spr_eval_pkg.sv
// Constants and types for the sprite evaluation block.
package spr_eval_pkg;

    // Store geometry.
    localparam int PRIMARY_BYTES = 256;
    localparam int SLOT_BYTES    = 32;
    localparam int PRIM_AW       = $clog2(PRIMARY_BYTES);
    localparam int SLOT_AW       = $clog2(SLOT_BYTES);

    // Frame timing.
    localparam logic [8:0] LINE_VISIBLE   = 9'd240;
    localparam logic [8:0] LINE_PRERENDER = 9'd261;
    localparam logic [8:0] DOT_LAST       = 9'd340;
    localparam logic [8:0] DOT_LAST_SHORT = 9'd339;
    localparam logic [8:0] DOT_CLEAR_LAST = 9'd64;
    localparam logic [8:0] DOT_EVAL_FIRST = 9'd65;
    localparam logic [8:0] DOT_EVAL_LAST  = 9'd256;
    localparam logic [8:0] DOT_COPY_FIRST = 9'd257;
    localparam logic [8:0] DOT_COPY_LAST  = 9'd320;

    // Sprite geometry.
    localparam logic [7:0] Y_LIMIT      = 8'd240;
    localparam logic [4:0] SHORT_HEIGHT = 5'd8;
    localparam logic [4:0] TALL_HEIGHT  = 5'd16;
    localparam logic [7:0] CLEAR_BYTE   = 8'hFF;

    // Address steps used by the scan.
    localparam logic [2:0] STEP_NONE = 3'd0;
    localparam logic [2:0] STEP_COPY = 3'd1;
    localparam logic [2:0] STEP_SKIP = 3'd4;
    localparam logic [2:0] STEP_OVER = 3'd5;

    // Operation codes carried in s_tuser.
    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_ADDR_WRITE = 2'd1,
        OP_DATA_WRITE = 2'd2,
        OP_DATA_READ  = 2'd3
    } op_t;

endpackage

// File: sv/sprite_evaluation_with_dot_timing.sv
// Sprite evaluation with dot-accurate timing, eight sprites per line.
//
// The block takes one transaction per clock on its input stream: either a video dot
// tick or an access to the 256-byte sprite attribute memory (address write, data
// write with post-increment, data read), selected by s_tuser. Every input
// transaction yields exactly one output transaction, registered at the edge that
// accepts it; the input stays ready while that register is empty or being drained,
// so the sustained rate is one transaction per clock. The attribute memory is a
// synchronous RAM that is read every cycle at the address the attribute pointer
// will hold after the current edge, so its registered read data always shows the
// byte under the pointer; writes only ever land at the old pointer, which the read
// never targets in the same cycle. A row of 256 valid flip-flops, cleared by
// reset, makes unwritten attribute bytes read as zero, so no clearing pass is
// needed after reset. The 32-byte secondary memory is read only on copy-out ticks
// and its registered data goes straight into slot_data of the waiting output
// transaction. On visible lines dots 1 to 64 clear the secondary memory to FF,
// dots 65 to 256 copy in-range sprites and then run the overflow scan that steps
// the address by five, and dots 257 to 320 copy the secondary bytes out in groups of
// four. Data reads during the clearing dots return FF. The tall_sprites register is
// written over its own channel; the user must do it only while idle (not enforced).
module sprite_evaluation_with_dot_timing (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] read_data, [8] overflow_flag, [13:9] slot_index,
                                   // [21:14] slot_data, [30:22] line_number,
                                   // [39:31] dot_number
    output logic [0:0]  m_tuser,   // [0] slot_write_valid
    // Configuration write channel.
    input  logic        cfg_wvalid,
    output logic        cfg_wready,
    input  logic        cfg_wdata
);

    localparam int PAW = spr_eval_pkg::PRIM_AW;
    localparam int SAW = spr_eval_pkg::SLOT_AW;

    // Phases of the sprite scan.
    typedef enum logic [2:0] {
        PH_SCAN = 3'd0,
        PH_TILE = 3'd1,
        PH_ATTR = 3'd2,
        PH_X    = 3'd3,
        PH_OVER = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    // Control state.
    logic [PAW-1:0] attr_reg,  attr_next;
    logic [SAW:0]   slot_reg,  slot_next;
    phase_t         phase_reg, phase_next;
    logic [7:0]     fetch_reg, fetch_next;
    logic           ovf_reg,   ovf_next;
    logic [8:0]     line_reg,  line_next;
    logic [8:0]     dot_reg,   dot_next;
    logic           odd_reg,   odd_next;
    logic           tall_reg;

    // Output register.
    logic           m_valid_reg;
    logic [7:0]     m_rd_reg,    m_rd_next;
    logic           m_ovf_reg;
    logic           m_svld_reg,  m_svld_next;
    logic [SAW-1:0] m_sidx_reg,  m_sidx_next;
    logic [8:0]     m_line_reg;
    logic [8:0]     m_dot_reg;

    // Attribute memory and its valid bits.
    logic [7:0]     prim_mem [spr_eval_pkg::PRIMARY_BYTES];
    logic           prim_vld [spr_eval_pkg::PRIMARY_BYTES];
    logic [7:0]     prim_q_reg;
    logic           prim_vq_reg;
    logic           prim_we;
    logic [7:0]     prim_byte;

    // Secondary memory.
    logic [7:0]     sec_mem [spr_eval_pkg::SLOT_BYTES];
    logic [7:0]     sec_q_reg;
    logic           sec_we;
    logic [SAW-1:0] sec_waddr;
    logic [7:0]     sec_wdata;
    logic           sec_re;
    logic [SAW-1:0] sec_raddr;

    // Working signals.
    logic                 accept;
    spr_eval_pkg::op_t    op;
    logic                 vis;
    logic                 y_hit;
    logic [9:0]           y_end;
    logic [4:0]           height;
    logic [2:0]           step;
    logic [PAW:0]         attr_sum;
    logic [SAW:0]         slot_base;
    logic [SAW:0]         slot_plus;
    logic [8:0]           dot_inc;
    logic [8:0]           line_inc;
    logic [8:0]           dot_m1;

    assign accept     = s_tvalid && s_tready;
    assign op         = spr_eval_pkg::op_t'(s_tuser);
    assign s_tready   = aresetn && (!m_valid_reg || m_tready);
    assign cfg_wready = aresetn;

    assign prim_byte = prim_vq_reg ? prim_q_reg : 8'd0;
    assign vis       = line_reg < spr_eval_pkg::LINE_VISIBLE;

    // A sprite is in range when its top is on or above this line, it is on screen,
    // and this line lies above its bottom.
    assign height   = tall_reg ? spr_eval_pkg::TALL_HEIGHT : spr_eval_pkg::SHORT_HEIGHT;
    assign y_end    = {2'b00, fetch_reg} + {5'd0, height};
    assign y_hit    = ({1'b0, fetch_reg} <= line_reg) && (fetch_reg < spr_eval_pkg::Y_LIMIT)
                      && ({1'b0, line_reg} < y_end);

    assign dot_m1   = dot_reg - 9'd1;
    assign dot_inc  = dot_reg + 9'd1;
    assign line_inc = line_reg + 9'd1;

    always_comb begin
        attr_next   = attr_reg;
        slot_next   = slot_reg;
        phase_next  = phase_reg;
        fetch_next  = fetch_reg;
        ovf_next    = ovf_reg;
        line_next   = line_reg;
        dot_next    = dot_reg;
        odd_next    = odd_reg;
        m_rd_next   = 8'd0;
        m_svld_next = 1'b0;
        m_sidx_next = '0;
        prim_we     = 1'b0;
        sec_we      = 1'b0;
        sec_waddr   = '0;
        sec_wdata   = 8'd0;
        sec_re      = 1'b0;
        sec_raddr   = '0;
        step        = spr_eval_pkg::STEP_NONE;
        attr_sum    = '0;
        slot_base   = slot_reg;
        slot_plus   = slot_reg + 1'b1;
        if (accept) begin
            unique case (op)
                spr_eval_pkg::OP_TICK: begin
                    if (line_reg == spr_eval_pkg::LINE_PRERENDER && dot_reg >= 9'd1 &&
                        dot_reg <= spr_eval_pkg::DOT_EVAL_LAST) begin
                        ovf_next = 1'b0;
                    end
                    if ((vis || line_reg == spr_eval_pkg::LINE_PRERENDER) &&
                        dot_reg >= spr_eval_pkg::DOT_COPY_FIRST &&
                        dot_reg <= spr_eval_pkg::DOT_COPY_LAST) begin
                        attr_next = '0;
                    end
                    if (vis) begin
                        if (dot_reg >= 9'd1 && dot_reg <= spr_eval_pkg::DOT_CLEAR_LAST) begin
                            // Clearing: one FF byte on every even dot.
                            if (!dot_reg[0]) begin
                                sec_we    = 1'b1;
                                sec_waddr = dot_reg[SAW:1];
                                sec_wdata = spr_eval_pkg::CLEAR_BYTE;
                            end
                        end else if (dot_reg >= spr_eval_pkg::DOT_EVAL_FIRST &&
                                     dot_reg <= spr_eval_pkg::DOT_EVAL_LAST) begin
                            if (dot_reg[0]) begin
                                // Odd dots fetch; the first one also restarts the scan.
                                fetch_next = prim_byte;
                                if (dot_reg == spr_eval_pkg::DOT_EVAL_FIRST) begin
                                    phase_next = PH_SCAN;
                                    slot_next  = '0;
                                end
                            end else begin
                                unique case (phase_reg)
                                    PH_SCAN: begin
                                        sec_we    = 1'b1;
                                        sec_waddr = slot_reg[SAW-1:0];
                                        sec_wdata = fetch_reg;
                                        if (y_hit) begin
                                            phase_next = PH_TILE;
                                            step       = spr_eval_pkg::STEP_COPY;
                                            slot_next  = slot_plus;
                                        end else begin
                                            step = spr_eval_pkg::STEP_SKIP;
                                        end
                                    end
                                    PH_TILE, PH_ATTR, PH_X: begin
                                        sec_we    = 1'b1;
                                        sec_waddr = slot_reg[SAW-1:0];
                                        sec_wdata = fetch_reg;
                                        step      = spr_eval_pkg::STEP_COPY;
                                        slot_next = slot_plus;
                                        if (phase_reg == PH_TILE) begin
                                            phase_next = PH_ATTR;
                                        end else if (phase_reg == PH_ATTR) begin
                                            phase_next = PH_X;
                                        end else begin
                                            // Eight sprites found once the slot
                                            // pointer reaches the top half.
                                            phase_next = slot_plus[SAW] ? PH_OVER : PH_SCAN;
                                        end
                                    end
                                    PH_OVER: begin
                                        if (y_hit) begin
                                            ovf_next   = 1'b1;
                                            phase_next = PH_DONE;
                                        end else begin
                                            step = spr_eval_pkg::STEP_OVER;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                                attr_sum  = {1'b0, attr_reg} + {{(PAW-2){1'b0}}, step};
                                attr_next = attr_sum[PAW-1:0];
                                // A carry out means the address wrapped past the end.
                                if (attr_sum[PAW]) begin
                                    phase_next = PH_DONE;
                                end
                            end
                        end else if (dot_reg >= spr_eval_pkg::DOT_COPY_FIRST &&
                                     dot_reg <= spr_eval_pkg::DOT_COPY_LAST) begin
                            if (dot_reg == spr_eval_pkg::DOT_COPY_FIRST) begin
                                slot_base = '0;
                            end
                            slot_next = slot_base;
                            // Four copy dots, then four idle dots.
                            if (!dot_m1[2]) begin
                                sec_re      = 1'b1;
                                sec_raddr   = slot_base[SAW-1:0];
                                m_svld_next = 1'b1;
                                m_sidx_next = slot_base[SAW-1:0];
                                slot_next   = slot_base + 1'b1;
                            end
                        end
                    end
                    // Frame position; the odd-frame pre-render line drops its last dot.
                    dot_next = dot_inc;
                    if (dot_inc > spr_eval_pkg::DOT_LAST ||
                        (dot_inc > spr_eval_pkg::DOT_LAST_SHORT && odd_reg &&
                         line_reg == spr_eval_pkg::LINE_PRERENDER)) begin
                        dot_next  = '0;
                        line_next = line_inc;
                        if (line_inc > spr_eval_pkg::LINE_PRERENDER) begin
                            line_next = '0;
                            odd_next  = !odd_reg;
                        end
                    end
                end
                spr_eval_pkg::OP_ADDR_WRITE: begin
                    attr_next = s_tdata;
                end
                spr_eval_pkg::OP_DATA_WRITE: begin
                    prim_we   = 1'b1;
                    attr_next = attr_reg + 1'b1;
                end
                spr_eval_pkg::OP_DATA_READ: begin
                    if (vis && dot_reg >= 9'd1 && dot_reg <= spr_eval_pkg::DOT_CLEAR_LAST) begin
                        m_rd_next = spr_eval_pkg::CLEAR_BYTE;
                    end else begin
                        m_rd_next = prim_byte;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control state and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg    <= '0;
            slot_reg    <= '0;
            phase_reg   <= PH_SCAN;
            fetch_reg   <= '0;
            ovf_reg     <= 1'b0;
            line_reg    <= spr_eval_pkg::LINE_PRERENDER;
            dot_reg     <= '0;
            odd_reg     <= 1'b0;
            tall_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            m_rd_reg    <= '0;
            m_ovf_reg   <= 1'b0;
            m_svld_reg  <= 1'b0;
            m_sidx_reg  <= '0;
            m_line_reg  <= '0;
            m_dot_reg   <= '0;
        end else begin
            attr_reg  <= attr_next;
            slot_reg  <= slot_next;
            phase_reg <= phase_next;
            fetch_reg <= fetch_next;
            ovf_reg   <= ovf_next;
            line_reg  <= line_next;
            dot_reg   <= dot_next;
            odd_reg   <= odd_next;
            if (cfg_wvalid) begin
                tall_reg <= cfg_wdata;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
                m_rd_reg    <= m_rd_next;
                m_ovf_reg   <= ovf_next;
                m_svld_reg  <= m_svld_next;
                m_sidx_reg  <= m_sidx_next;
                m_line_reg  <= line_reg;
                m_dot_reg   <= dot_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Attribute memory: written at the current pointer, read at the next one.
    always_ff @(posedge aclk) begin
        if (prim_we) begin
            prim_mem[attr_reg] <= s_tdata;
        end
        prim_q_reg <= prim_mem[attr_next];
    end

    // Valid bits: an attribute byte never written reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < spr_eval_pkg::PRIMARY_BYTES; i++) begin
                prim_vld[i] <= 1'b0;
            end
            prim_vq_reg <= 1'b0;
        end else begin
            if (prim_we) begin
                prim_vld[attr_reg] <= 1'b1;
            end
            prim_vq_reg <= prim_vld[attr_next];
        end
    end

    // Secondary memory: read data is held until the next copy-out tick.
    always_ff @(posedge aclk) begin
        if (sec_we) begin
            sec_mem[sec_waddr] <= sec_wdata;
        end
        if (sec_re) begin
            sec_q_reg <= sec_mem[sec_raddr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_svld_reg;
    assign m_tdata  = {m_dot_reg, m_line_reg, (m_svld_reg ? sec_q_reg : 8'd0),
                       m_sidx_reg, m_ovf_reg, m_rd_reg};

`include "sprite_evaluation_with_dot_timing_macros.svh"

    // Slot copies only come out of the copy-out window of a visible line.
    `SPR_ASSERT_NOW(a_slot_window, m_valid_reg && m_svld_reg, (m_line_reg < spr_eval_pkg::LINE_VISIBLE) && (m_dot_reg >= spr_eval_pkg::DOT_COPY_FIRST) && (m_dot_reg <= spr_eval_pkg::DOT_COPY_LAST), "slot copy outside the copy-out window")

    // A tick on the last dot of a line starts the next line at dot zero.
    `SPR_ASSERT_NEXT(a_line_wrap, accept && op == spr_eval_pkg::OP_TICK && dot_reg == spr_eval_pkg::DOT_LAST, dot_reg == 9'd0, "dot counter did not wrap")

    // Ticks early on the pre-render line clear the overflow status.
    `SPR_ASSERT_NEXT(a_ovf_clear, accept && op == spr_eval_pkg::OP_TICK && line_reg == spr_eval_pkg::LINE_PRERENDER && dot_reg >= 9'd1 && dot_reg <= spr_eval_pkg::DOT_EVAL_LAST, !ovf_reg, "overflow not cleared on pre-render line")

endmodule

// File: bench/sprite_evaluation_with_dot_timing_tb.sv
// Self-checking testbench for the dot-timed sprite evaluation block.
`timescale 1ns / 100ps

module sprite_evaluation_with_dot_timing_tb;

    // The output word as it sits in m_tdata, highest field first.
    typedef struct packed {
        logic [8:0] dot;
        logic [8:0] line;
        logic [7:0] sdata;
        logic [4:0] sidx;
        logic       ovf;
        logic [7:0] rd;
    } result_word_t;

    // One predicted output transaction: the data word plus the slot write flag from m_tuser.
    typedef struct {
        result_word_t word;
        logic         slot_valid;
    } dot_result_t;

    // Steps of the sprite scan within the evaluation dots of a visible line.
    typedef enum {
        SEEK_Y,
        MOVE_TILE,
        MOVE_ATTR,
        MOVE_X,
        OVERFLOW_SCAN,
        SCAN_DONE
    } scan_step_t;

    // Mirror of the block. It tracks the frame position, both sprite stores and the scan,
    // works out the output of every accepted input transaction and compares it with what
    // the block returns, oldest first.
    class dot_timeline;
        logic [7:0]  primary [spr_eval_pkg::PRIMARY_BYTES];
        logic [7:0]  secondary [spr_eval_pkg::SLOT_BYTES];
        logic [7:0]  attr_ptr;
        logic [5:0]  slot_ptr;
        scan_step_t  step;
        logic [7:0]  latched;
        logic        overflow;
        int unsigned line_pos;
        int unsigned dot_pos;
        bit          odd_frame;
        bit          tall;
        dot_result_t pending_dots [$];
        int          mismatch_count;

        function new();
            foreach (primary[i]) primary[i] = 8'h00;
            foreach (secondary[i]) secondary[i] = 8'h00;
            attr_ptr = 8'h00;
            slot_ptr = 6'd0;
            step = SEEK_Y;
            latched = 8'h00;
            overflow = 1'b0;
            line_pos = spr_eval_pkg::LINE_PRERENDER;
            dot_pos = 0;
            odd_frame = 1'b0;
            tall = 1'b0;
            mismatch_count = 0;
        endfunction

        function bit sprite_hit();
            int unsigned y;
            int unsigned h;
            y = latched;
            h = tall ? 16 : 8;
            return y <= line_pos && y < 240 && line_pos < y + h;
        endfunction

        function void copy_byte();
            secondary[slot_ptr[4:0]] = latched;
            attr_ptr = attr_ptr + 8'd1;
            slot_ptr = slot_ptr + 6'd1;
        endfunction

        // One evaluation dot: odd dots fetch, even dots act on the fetched byte.
        function void evaluate_dot();
            logic [7:0] prev_ptr;
            if (dot_pos == 65) begin
                step = SEEK_Y;
                slot_ptr = 6'd0;
            end
            if (dot_pos & 1) begin
                latched = primary[attr_ptr];
                return;
            end
            prev_ptr = attr_ptr;
            case (step)
                SEEK_Y: begin
                    if (sprite_hit()) begin
                        copy_byte();
                        step = MOVE_TILE;
                    end else begin
                        secondary[slot_ptr[4:0]] = latched;
                        attr_ptr = attr_ptr + 8'd4;
                    end
                end
                MOVE_TILE: begin
                    copy_byte();
                    step = MOVE_ATTR;
                end
                MOVE_ATTR: begin
                    copy_byte();
                    step = MOVE_X;
                end
                MOVE_X: begin
                    copy_byte();
                    step = (slot_ptr >= 6'd32) ? OVERFLOW_SCAN : SEEK_Y;
                end
                OVERFLOW_SCAN: begin
                    // The faulty scan: a miss steps by five, so it drifts through the
                    // tile, attribute and X bytes and reads them as Y coordinates.
                    if (sprite_hit()) begin
                        overflow = 1'b1;
                        step = SCAN_DONE;
                    end else begin
                        attr_ptr = attr_ptr + 8'd5;
                    end
                end
                default: ;
            endcase
            // Running off the end of the attribute memory ends the scan for this line.
            if (prev_ptr > attr_ptr)
                step = SCAN_DONE;
        endfunction

        function void step_position();
            dot_pos++;
            if (dot_pos > spr_eval_pkg::DOT_LAST ||
                (dot_pos > spr_eval_pkg::DOT_LAST_SHORT && odd_frame &&
                 line_pos >= spr_eval_pkg::LINE_PRERENDER)) begin
                line_pos++;
                dot_pos = 0;
            end
            if (line_pos > spr_eval_pkg::LINE_PRERENDER) begin
                line_pos = 0;
                odd_frame = !odd_frame;
            end
        endfunction

        // Notes an accepted input transaction and queues the output it must produce.
        function void take_item(spr_eval_pkg::op_t op, logic [7:0] data);
            dot_result_t r;
            bit          visible;
            r.word = '0;
            r.slot_valid = 1'b0;
            r.word.line = line_pos[8:0];
            r.word.dot = dot_pos[8:0];
            visible = line_pos < spr_eval_pkg::LINE_VISIBLE;
            case (op)
                spr_eval_pkg::OP_TICK: begin
                    if (line_pos == spr_eval_pkg::LINE_PRERENDER && dot_pos >= 1 &&
                        dot_pos <= 256)
                        overflow = 1'b0;
                    if ((visible || line_pos == spr_eval_pkg::LINE_PRERENDER) &&
                        dot_pos >= 257 && dot_pos <= 320)
                        attr_ptr = 8'h00;
                    if (visible) begin
                        if (dot_pos >= 1 && dot_pos <= 64) begin
                            if ((dot_pos & 1) == 0)
                                secondary[dot_pos[5:1]] = 8'hFF;
                        end else if (dot_pos >= 65 && dot_pos <= 256) begin
                            evaluate_dot();
                        end else if (dot_pos >= 257 && dot_pos <= 320) begin
                            if (dot_pos == 257)
                                slot_ptr = 6'd0;
                            // Copy-out runs in groups of four dots with four idle dots between.
                            if (((dot_pos - 1) & 4) == 0) begin
                                r.word.sidx = slot_ptr[4:0];
                                r.word.sdata = secondary[slot_ptr[4:0]];
                                r.slot_valid = 1'b1;
                                slot_ptr = slot_ptr + 6'd1;
                            end
                        end
                    end
                    step_position();
                end
                spr_eval_pkg::OP_ADDR_WRITE: attr_ptr = data;
                spr_eval_pkg::OP_DATA_WRITE: begin
                    primary[attr_ptr] = data;
                    attr_ptr = attr_ptr + 8'd1;
                end
                default: begin
                    if (visible && dot_pos >= 1 && dot_pos <= 64)
                        r.word.rd = 8'hFF;
                    else
                        r.word.rd = primary[attr_ptr];
                end
            endcase
            r.word.ovf = overflow;
            pending_dots.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatch_count++;
                if (mismatch_count <= 20)
                    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void match_output(logic [39:0] tdata, logic tuser);
            result_word_t got;
            dot_result_t  want;
            if (pending_dots.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 20)
                    $display("%0t: unexpected output transaction, expected none, got %h/%b",
                             $time, tdata, tuser);
                return;
            end
            got = tdata;
            want = pending_dots.pop_front();
            compare_field("read_data", 32'(want.word.rd), 32'(got.rd));
            compare_field("overflow_flag", 32'(want.word.ovf), 32'(got.ovf));
            compare_field("slot_write_valid", 32'(want.slot_valid), 32'(tuser));
            compare_field("slot_index", 32'(want.word.sidx), 32'(got.sidx));
            compare_field("slot_data", 32'(want.word.sdata), 32'(got.sdata));
            compare_field("line_number", 32'(want.word.line), 32'(got.line));
            compare_field("dot_number", 32'(want.word.dot), 32'(got.dot));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data
    logic [1:0]  s_tuser;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [7:0] read_data, [8] overflow_flag, [13:9] slot_index,
                            // [21:14] slot_data, [30:22] line_number, [39:31] dot_number
    logic [0:0]  m_tuser;   // [0] slot_write_valid
    logic        cfg_wvalid;
    logic        cfg_wready;
    logic        cfg_wdata;

    dot_timeline timeline;
    int unsigned cycle_no;
    int unsigned results_seen;
    int unsigned hold_left;
    bit          hold_done;
    wire         calm = cycle_no >= 150 && cycle_no < 450;

    sprite_evaluation_with_dot_timing DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wvalid (cfg_wvalid),
        .cfg_wready (cfg_wready),
        .cfg_wdata  (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
    end

    // Every output transaction is checked at the edge that accepts it. The block registers
    // its output, so the matching input transaction was always noted at an earlier edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            timeline.match_output(m_tdata, m_tuser[0]);
            results_seen++;
        end
    end

    // Receiver. It mostly accepts, drops m_tready at random about 15 times in a hundred, stays
    // steady through the calm window, and once holds off for a long stretch so that the
    // output register fills and the block has to stall its input.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && results_seen >= 500) begin
                hold_done = 1'b1;
                hold_left = 300;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // Offers one input transaction from the falling edge and waits for its acceptance. The
    // valid stays high after acceptance until the next call, so back-to-back transactions
    // never see it lowered and raised within one time step.
    task automatic send_item(spr_eval_pkg::op_t op, logic [7:0] data);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        timeline.take_item(op, data);
    endtask

    // Stops offering and waits until every output transaction has come back.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (timeline.pending_dots.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_height(bit tall_bit);
        @(negedge aclk);
        cfg_wvalid <= 1'b1;
        cfg_wdata <= tall_bit;
        do @(posedge aclk); while (!cfg_wready);
        timeline.tall = tall_bit;
        @(negedge aclk);
        cfg_wvalid <= 1'b0;
    endtask

    // Stray attribute access in the middle of the dot stream. Reads are harmless; writes
    // move the attribute pointer and so disturb any scan that is running.
    task automatic stray_access();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send_item(spr_eval_pkg::OP_DATA_READ, 8'($urandom_range(0, 255)));
        else if (pick < 80)
            send_item(spr_eval_pkg::OP_DATA_WRITE, 8'($urandom_range(0, 255)));
        else
            send_item(spr_eval_pkg::OP_ADDR_WRITE, 8'($urandom_range(0, 255)));
    endtask

    // Loads a batch of sprite entries aimed at the next line. Most Y coordinates put the
    // sprite in range so that eight-sprite lines and the overflow scan come up often.
    task automatic program_sprites();
        int unsigned next_line;
        int unsigned height;
        int unsigned count;
        int unsigned y;
        logic [5:0]  entry;
        next_line = (timeline.line_pos == spr_eval_pkg::LINE_PRERENDER) ?
                    0 : timeline.line_pos + 1;
        height = timeline.tall ? 16 : 8;
        count = $urandom_range(10, 20);
        repeat (count) begin
            entry = 6'($urandom_range(0, 63));
            send_item(spr_eval_pkg::OP_ADDR_WRITE, {entry, 2'b00});
            if ($urandom_range(0, 9) < 7 && next_line < spr_eval_pkg::LINE_VISIBLE) begin
                y = $urandom_range(0, height - 1);
                y = (y > next_line) ? 0 : next_line - y;
            end else begin
                y = $urandom_range(0, 255);
            end
            send_item(spr_eval_pkg::OP_DATA_WRITE, y[7:0]);
            repeat (3) send_item(spr_eval_pkg::OP_DATA_WRITE, 8'($urandom_range(0, 255)));
        end
    endtask

    // Ticks on until the frame reaches the given dot of the given line. Sprites are loaded
    // during the copy-out dots, where the following ticks put the attribute pointer back
    // to zero before the next line is scanned.
    task automatic run_to(int unsigned stop_line, int unsigned stop_dot,
                          int unsigned load_pct);
        do begin
            if (timeline.dot_pos == 300 &&
                (timeline.line_pos < spr_eval_pkg::LINE_VISIBLE ||
                 timeline.line_pos == spr_eval_pkg::LINE_PRERENDER) &&
                $urandom_range(0, 99) < load_pct)
                program_sprites();
            if ($urandom_range(0, 99) < 3)
                stray_access();
            send_item(spr_eval_pkg::OP_TICK, 8'($urandom_range(0, 255)));
        end while (!(timeline.line_pos == stop_line && timeline.dot_pos == stop_dot));
    endtask

    initial begin
        timeline = new();
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = spr_eval_pkg::OP_TICK;
        m_tready = 1'b0;
        cfg_wvalid = 1'b0;
        cfg_wdata = 1'b0;
        cycle_no = 0;
        results_seen = 0;
        hold_left = 0;
        hold_done = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_height(1'b0);

        // Directed opening: every operation, both ends of the data byte and the pointer
        // wrapping from FF back to 00 on a data write.
        send_item(spr_eval_pkg::OP_DATA_READ, 8'hFF);
        send_item(spr_eval_pkg::OP_DATA_WRITE, 8'hFF);
        send_item(spr_eval_pkg::OP_ADDR_WRITE, 8'hFF);
        send_item(spr_eval_pkg::OP_DATA_WRITE, 8'h00);
        send_item(spr_eval_pkg::OP_DATA_READ, 8'h00);
        send_item(spr_eval_pkg::OP_ADDR_WRITE, 8'h00);
        send_item(spr_eval_pkg::OP_DATA_READ, 8'h00);
        send_item(spr_eval_pkg::OP_ADDR_WRITE, 8'hA5);
        send_item(spr_eval_pkg::OP_DATA_WRITE, 8'h5A);
        send_item(spr_eval_pkg::OP_ADDR_WRITE, 8'hA5);
        send_item(spr_eval_pkg::OP_DATA_READ, 8'hFF);
        send_item(spr_eval_pkg::OP_ADDR_WRITE, 8'h00);
        send_item(spr_eval_pkg::OP_TICK, 8'hFF);
        send_item(spr_eval_pkg::OP_TICK, 8'h00);
        send_item(spr_eval_pkg::OP_DATA_READ, 8'h55);

        // The pre-render line loads sprites for line 0. Line 0 clears, then scans with
        // short sprites up to the middle of its evaluation dots and finishes the scan and
        // the copy-out with tall ones.
        run_to(0, 0, 100);
        run_to(0, 160, 0);
        settle();
        write_height(1'b1);
        run_to(1, 0, 0);

        settle();
        repeat (20) @(posedge aclk);
        if (timeline.mismatch_count == 0 && timeline.pending_dots.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/spr_eval_pkg.sv
sv/sprite_evaluation_with_dot_timing.sv
bench/sprite_evaluation_with_dot_timing_tb.sv
